[hdl/mmn_pkg.sv]
// Package: shared constants, codes and types of the median/mean normalizer.
`default_nettype none

package mmn_pkg;

   localparam int N_CHANNELS     = 6;
   localparam int SAMPLE_BITS    = 8;
   localparam int LEVEL_BITS     = 7;
   localparam int BIAS_BITS      = 8;
   localparam int SUM_BITS       = 10;
   localparam int CFG_BITS       = N_CHANNELS * SAMPLE_BITS;
   localparam int CSR_INDEX_BITS = 8;
   localparam int SCANS_PER_MEAN = 12;
   localparam int SCAN_CNT_BITS  = 4;
   localparam int QUO_BITS       = LEVEL_BITS;
   localparam int BIT_IDX_BITS   = $clog2(QUO_BITS);
   localparam int REM_BITS       = SAMPLE_BITS + LEVEL_BITS;
   localparam int PERCENT_FULL   = 100;
   localparam int BIAS_LEFT      = 1;
   localparam int BIAS_RIGHT     = (N_CHANNELS > 4) ? 4 : (N_CHANNELS - 1);

   localparam logic [CSR_INDEX_BITS-1:0] REG_MIN_LEVELS = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_MAX_LEVELS = CSR_INDEX_BITS'(1);

   // position of a scan inside its triple
   typedef enum logic [1:0] {
      SLOT_FIRST,
      SLOT_SECOND,
      SLOT_THIRD
   } slot_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   // sequencer to lanes
   typedef struct packed {
      logic                    scan_en;
      slot_type                slot;
      logic                    last;
      logic                    prep;
      logic                    step;
      logic [BIT_IDX_BITS-1:0] bit_idx;
   } lane_ctl_type;

endpackage

`default_nettype wire

[hdl/mmn_ifs.sv]
// Interfaces: scan request, level response and register write channels.
`default_nettype none

interface mmn_req_if;
   import mmn_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample0;
   logic [SAMPLE_BITS-1:0] sample1;
   logic [SAMPLE_BITS-1:0] sample2;
   logic [SAMPLE_BITS-1:0] sample3;
   logic [SAMPLE_BITS-1:0] sample4;
   logic [SAMPLE_BITS-1:0] sample5;
   modport source (output valid, sample0, sample1, sample2, sample3, sample4, sample5,
                   input ready);
   modport sink   (input valid, sample0, sample1, sample2, sample3, sample4, sample5,
                   output ready);
endinterface

interface mmn_rsp_if;
   import mmn_pkg::*;
   logic                        valid;
   logic                        ready;
   logic [LEVEL_BITS-1:0]       level0;
   logic [LEVEL_BITS-1:0]       level1;
   logic [LEVEL_BITS-1:0]       level2;
   logic [LEVEL_BITS-1:0]       level3;
   logic [LEVEL_BITS-1:0]       level4;
   logic [LEVEL_BITS-1:0]       level5;
   logic signed [BIAS_BITS-1:0] steer_bias;
   modport source (output valid, level0, level1, level2, level3, level4, level5, steer_bias,
                   input ready);
   modport sink   (input valid, level0, level1, level2, level3, level4, level5, steer_bias,
                   output ready);
endinterface

interface mmn_csr_if;
   import mmn_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CFG_BITS-1:0]       data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/mmn_lane.sv]
// Lane: one channel's median-of-three, mean-of-four and percent divider.
`default_nettype none

module mmn_lane (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire mmn_pkg::lane_ctl_type           ctl,
   input  wire logic [mmn_pkg::SAMPLE_BITS-1:0] sample,
   input  wire logic [mmn_pkg::SAMPLE_BITS-1:0] min_level,
   input  wire logic [mmn_pkg::SAMPLE_BITS-1:0] max_level,
   output logic      [mmn_pkg::LEVEL_BITS-1:0]  level
);
   import mmn_pkg::*;

   logic [SAMPLE_BITS-1:0] buf0_ff, buf0_in;
   logic [SAMPLE_BITS-1:0] buf1_ff, buf1_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0] mean_ff, mean_in;
   logic [SAMPLE_BITS-1:0] div_ff, div_in;
   logic [REM_BITS-1:0]    rem_ff, rem_in;
   logic [QUO_BITS-1:0]    quo_ff, quo_in;
   logic                   zero_ff, zero_in;
   logic                   full_ff, full_in;

   logic [SAMPLE_BITS-1:0] lo, hi, mid, med;
   logic [SUM_BITS-1:0]    sum_next;
   logic [REM_BITS-1:0]    shifted;

   always_comb begin
      // median of buffered pair and the new sample
      lo  = (buf0_ff < buf1_ff) ? buf0_ff : buf1_ff;
      hi  = (buf0_ff < buf1_ff) ? buf1_ff : buf0_ff;
      mid = (hi < sample) ? hi : sample;
      med = (lo > mid) ? lo : mid;
      sum_next = sum_ff + SUM_BITS'(med);
      shifted  = REM_BITS'(div_ff) << ctl.bit_idx;

      buf0_in = buf0_ff;
      buf1_in = buf1_ff;
      sum_in  = sum_ff;
      mean_in = mean_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      zero_in = zero_ff;
      full_in = full_ff;

      if (ctl.scan_en) begin
         case (ctl.slot)
            SLOT_FIRST:  buf0_in = sample;
            SLOT_SECOND: buf1_in = sample;
            SLOT_THIRD: begin
               if (ctl.last) begin
                  sum_in  = '0;
                  mean_in = sum_next[SUM_BITS-1 -: SAMPLE_BITS];
               end else begin
                  sum_in = sum_next;
               end
            end
            default: ;
         endcase
      end

      if (ctl.prep) begin
         // empty span or mean at/below min -> 0; mean at/above max -> full scale
         zero_in = (max_level <= min_level) || (mean_ff <= min_level);
         full_in = (mean_ff >= max_level);
         div_in  = max_level - min_level;
         rem_in  = REM_BITS'(mean_ff - min_level) * REM_BITS'(PERCENT_FULL);
         quo_in  = '0;
      end

      if (ctl.step) begin
         if (rem_ff >= shifted) begin
            rem_in              = rem_ff - shifted;
            quo_in[ctl.bit_idx] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      buf0_ff <= buf0_in;
      buf1_ff <= buf1_in;
      mean_ff <= mean_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      zero_ff <= zero_in;
      full_ff <= full_in;
   end

   always_comb begin
      if (zero_ff) begin
         level = '0;
      end else if (full_ff) begin
         level = LEVEL_BITS'(PERCENT_FULL);
      end else begin
         level = quo_ff;
      end
   end

endmodule

`default_nettype wire

[hdl/mmn_merge.sv]
// Merge: gathers lane levels, forms the steering bias, holds the response.
`default_nettype none

module mmn_merge (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           capture,
   input  wire logic [mmn_pkg::LEVEL_BITS-1:0] levels [mmn_pkg::N_CHANNELS],
   output logic                                full,
   mmn_rsp_if.source                           rsp
);
   import mmn_pkg::*;

   logic                        valid_ff, valid_in;
   logic [LEVEL_BITS-1:0]       level_ff [N_CHANNELS];
   logic [LEVEL_BITS-1:0]       level_in [N_CHANNELS];
   logic signed [BIAS_BITS-1:0] bias_ff, bias_in;

   always_comb begin
      valid_in = valid_ff;
      level_in = level_ff;
      bias_in  = bias_ff;
      if (rsp.ready) begin
         valid_in = 1'b0;
      end
      if (capture) begin
         valid_in = 1'b1;
         level_in = levels;
         bias_in  = BIAS_BITS'(levels[BIAS_LEFT]) - BIAS_BITS'(levels[BIAS_RIGHT]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
      bias_ff  <= bias_in;
   end

   assign full           = valid_ff;
   assign rsp.valid      = valid_ff;
   assign rsp.level0     = level_ff[0];
   assign rsp.level1     = level_ff[1];
   assign rsp.level2     = level_ff[2];
   assign rsp.level3     = level_ff[3];
   assign rsp.level4     = level_ff[4];
   assign rsp.level5     = level_ff[5];
   assign rsp.steer_bias = bias_ff;

endmodule

`default_nettype wire

[hdl/median_mean_normalize_core.sv]
// Top level: scan sequencer, calibration registers, six lanes and merge stage.
`default_nettype none

// Channel   Dir   Payload                                  Transaction
// req_ch    in    sample0..sample5, 8 b unsigned each      one scan of all channels
// rsp_ch    out   level0..level5 7 b, steer_bias 8 b s     one normalized result
// csr_ch    in    index 8 b, data 48 b                     one register write
//
// Flow: one scan accepted per cycle. Every twelfth scan launches the
//   normalize pass: a prep state, 7 restoring divide steps (one quotient bit
//   per cycle, all lanes in parallel) and a capture state; rsp_ch.valid is
//   registered from the capture state.
// Stalls: scans keep flowing during the divide; only a twelfth scan waits,
//   while a divide runs or the previous result is still unclaimed.
// Reset: synchronous, clears sums, counters, sequencer and result valid;
//   min_levels resets to 0, max_levels to all ones. No clearing pass.
module median_mean_normalize_core (
   input  wire logic clock,
   input  wire logic reset,
   mmn_req_if.sink   req_ch,
   mmn_rsp_if.source rsp_ch,
   mmn_csr_if.sink   csr_ch
);
   import mmn_pkg::*;

   localparam logic [SCAN_CNT_BITS-1:0] LAST_SCAN = SCAN_CNT_BITS'(SCANS_PER_MEAN - 1);

   state_type                 state_ff, state_in;
   logic [SCAN_CNT_BITS-1:0]  scan_cnt_ff, scan_cnt_in;
   slot_type                  slot_ff, slot_in;
   logic [BIT_IDX_BITS-1:0]   bit_ff, bit_in;
   logic [CFG_BITS-1:0]       min_levels_ff, min_levels_in;
   logic [CFG_BITS-1:0]       max_levels_ff, max_levels_in;

   lane_ctl_type              ctl;
   logic                      scan_last;
   logic                      req_take;
   logic                      capture;
   logic                      rsp_full;
   logic [SAMPLE_BITS-1:0]    samples [N_CHANNELS];
   logic [LEVEL_BITS-1:0]     levels  [N_CHANNELS];

   assign samples[0] = req_ch.sample0;
   assign samples[1] = req_ch.sample1;
   assign samples[2] = req_ch.sample2;
   assign samples[3] = req_ch.sample3;
   assign samples[4] = req_ch.sample4;
   assign samples[5] = req_ch.sample5;

   // config is to be written only while idle; the block does not enforce it, so always ready
   assign csr_ch.ready = 1'b1;

   always_comb begin
      min_levels_in = min_levels_ff;
      max_levels_in = max_levels_ff;
      if (csr_ch.valid) begin
         if (csr_ch.index == REG_MIN_LEVELS) begin
            min_levels_in = csr_ch.data;
         end else if (csr_ch.index == REG_MAX_LEVELS) begin
            max_levels_in = csr_ch.data;
         end
      end
   end

   // twelfth scan may only launch when the divider and result reg are free
   assign scan_last    = (scan_cnt_ff == LAST_SCAN);
   assign req_ch.ready = !(scan_last && ((state_ff != ST_IDLE) || rsp_full));
   assign req_take     = req_ch.valid && req_ch.ready;

   always_comb begin
      scan_cnt_in = scan_cnt_ff;
      slot_in     = slot_ff;
      if (req_take) begin
         scan_cnt_in = scan_last ? '0 : scan_cnt_ff + SCAN_CNT_BITS'(1);
         case (slot_ff)
            SLOT_FIRST:  slot_in = SLOT_SECOND;
            SLOT_SECOND: slot_in = SLOT_THIRD;
            SLOT_THIRD:  slot_in = SLOT_FIRST;
            default:     slot_in = SLOT_FIRST;
         endcase
      end
   end

   // sequencer: next state and lane controls
   always_comb begin
      state_in    = state_ff;
      bit_in      = bit_ff;
      capture     = 1'b0;
      ctl.scan_en = req_take;
      ctl.slot    = slot_ff;
      ctl.last    = scan_last;
      ctl.prep    = 1'b0;
      ctl.step    = 1'b0;
      ctl.bit_idx = bit_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && scan_last) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            ctl.prep = 1'b1;
            bit_in   = BIT_IDX_BITS'(QUO_BITS - 1);
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            ctl.step = 1'b1;
            if (bit_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               bit_in = bit_ff - BIT_IDX_BITS'(1);
            end
         end
         ST_FINISH: begin
            capture  = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         scan_cnt_ff   <= '0;
         slot_ff       <= SLOT_FIRST;
         bit_ff        <= '0;
         min_levels_ff <= '0;
         max_levels_ff <= '1;
      end else begin
         state_ff      <= state_in;
         scan_cnt_ff   <= scan_cnt_in;
         slot_ff       <= slot_in;
         bit_ff        <= bit_in;
         min_levels_ff <= min_levels_in;
         max_levels_ff <= max_levels_in;
      end
   end

   for (genvar ch = 0; ch < N_CHANNELS; ch++) begin : g_lane
      mmn_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .sample    (samples[ch]),
         .min_level (min_levels_ff[ch*SAMPLE_BITS +: SAMPLE_BITS]),
         .max_level (max_levels_ff[ch*SAMPLE_BITS +: SAMPLE_BITS]),
         .level     (levels[ch])
      );
   end

   mmn_merge u_merge (
      .clock   (clock),
      .reset   (reset),
      .capture (capture),
      .levels  (levels),
      .full    (rsp_full),
      .rsp     (rsp_ch)
   );

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Testbench for median_mean_normalize_core: random scans checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
   import mmn_pkg::*;

   // scan item: one byte per channel, channel 0 in the low byte
   typedef logic [N_CHANNELS-1:0][SAMPLE_BITS-1:0] scan_type;

   // one normalized result
   typedef struct packed {
      logic signed [BIAS_BITS-1:0]             bias;
      logic [N_CHANNELS-1:0][LEVEL_BITS-1:0]   level;
   } level_set_type;

   // Indexes with no register behind them; writes there must be dropped.
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNMAPPED_LOW = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNMAPPED_TOP = '1;

   localparam int CLOCK_PERIOD   = 8;
   localparam int RESET_CYCLES   = 5;
   // Result follows the twelfth scan once the divide is done; leave margin.
   localparam int SETTLE_CYCLES  = 24;
   localparam int HOLD_CYCLES    = 400;
   localparam int RANDOM_PHASES  = 8;
   localparam longint RUN_LIMIT_NS = 2_000_000;

   logic clock;
   logic reset;

   mmn_req_if req_ch ();
   mmn_rsp_if rsp_ch ();
   mmn_csr_if csr_ch ();

   median_mean_normalize_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Stimulus and scoreboard storage
   scan_type      pending_scans[$];
   level_set_type expected_levels[$];
   int            error_count = 0;

   // Handshake flags: set at the rising edge, used by the falling-edge drivers.
   logic scan_taken = 1'b0;

   // Idle percentages, set per phase by the sequencer.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // Long receiver hold-off: the sequencer bumps hold_requests, the receiver
   // notices and counts the stretch down in its own process.
   int hold_requests = 0;
   int hold_seen     = 0;
   int hold_left     = 0;

   // ---------------------------------------------------------------------
   // Predictor state: calibration copy plus the median/mean accumulators.
   // ---------------------------------------------------------------------
   logic [CFG_BITS-1:0]    cal_min;
   logic [CFG_BITS-1:0]    cal_max;
   logic [SAMPLE_BITS-1:0] triple_hold[2*N_CHANNELS];
   logic [SUM_BITS-1:0]    median_sum[N_CHANNELS];
   int                     scans_in_mean;

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD/2) clock = ~clock;
   end

   function automatic int median_of_three(input int a, input int b, input int c);
      int lo;
      int hi;
      int m;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      m  = (hi < c) ? hi : c;
      return (lo > m) ? lo : m;
   endfunction

   // (mean - min) * 100 / (max - min), truncated toward zero, clamped 0..100.
   // A zero or negative span reads as level 0.
   function automatic int percent_level(input int mean, input int ch);
      int lo;
      int hi;
      int span;
      int q;
      lo   = int'(cal_min[ch*SAMPLE_BITS +: SAMPLE_BITS]);
      hi   = int'(cal_max[ch*SAMPLE_BITS +: SAMPLE_BITS]);
      span = hi - lo;
      if (span <= 0) return 0;
      q = ((mean - lo) * PERCENT_FULL) / span;
      if (q < 0) q = 0;
      if (q > PERCENT_FULL) q = PERCENT_FULL;
      return q;
   endfunction

   // Advance the filter by one accepted scan; queue a result on every 12th.
   function automatic void predict_scan(input scan_type s);
      int            slot;
      int            lv[N_CHANNELS];
      level_set_type r;
      slot = scans_in_mean % 3;
      for (int ch = 0; ch < N_CHANNELS; ch++) begin
         if (slot < 2) begin
            triple_hold[2*ch + slot] = s[ch];
         end else begin
            median_sum[ch] = median_sum[ch] + SUM_BITS'(median_of_three(
               int'(triple_hold[2*ch]), int'(triple_hold[2*ch + 1]), int'(s[ch])));
         end
      end
      scans_in_mean++;
      if (scans_in_mean < SCANS_PER_MEAN) return;
      for (int ch = 0; ch < N_CHANNELS; ch++) begin
         lv[ch]       = percent_level(int'(median_sum[ch]) / 4, ch);
         r.level[ch]  = LEVEL_BITS'(lv[ch]);
         median_sum[ch] = '0;
      end
      r.bias = BIAS_BITS'(lv[BIAS_LEFT] - lv[BIAS_RIGHT]);
      expected_levels.push_back(r);
      scans_in_mean = 0;
   endfunction

   // ---------------------------------------------------------------------
   // Rising edge: observe both handshakes. Results are checked before the
   // scan of the same edge is predicted, so a stray result cannot match it.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      level_set_type got;
      level_set_type want;
      scan_taken = !reset && req_ch.valid && req_ch.ready;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.level[0] = rsp_ch.level0;
         got.level[1] = rsp_ch.level1;
         got.level[2] = rsp_ch.level2;
         got.level[3] = rsp_ch.level3;
         got.level[4] = rsp_ch.level4;
         got.level[5] = rsp_ch.level5;
         got.bias     = rsp_ch.steer_bias;
         if (expected_levels.size() == 0) begin
            $display("%0t: result with nothing expected: levels %h bias %0d",
                     $realtime, got.level, got.bias);
            error_count++;
         end else begin
            want = expected_levels.pop_front();
            for (int ch = 0; ch < N_CHANNELS; ch++) begin
               if (got.level[ch] !== want.level[ch]) begin
                  $display("%0t: level%0d expected %0d actual %0d",
                           $realtime, ch, want.level[ch], got.level[ch]);
                  error_count++;
               end
            end
            if (got.bias !== want.bias) begin
               $display("%0t: steer_bias expected %0d actual %0d",
                        $realtime, want.bias, got.bias);
               error_count++;
            end
         end
      end
      if (scan_taken)
         predict_scan({req_ch.sample5, req_ch.sample4, req_ch.sample3,
                       req_ch.sample2, req_ch.sample1, req_ch.sample0});
   end

   // ---------------------------------------------------------------------
   // Scan driver: falling edge. A raised valid stays up until its
   // transaction completes; otherwise offer the next scan unless idling.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      scan_type s;
      if (scan_taken) void'(pending_scans.pop_front());
      if (req_ch.valid && !scan_taken) begin
         // still waiting on ready: hold everything
      end else if (!reset && pending_scans.size() != 0 &&
                   $urandom_range(0, 99) >= send_idle_pct) begin
         s = pending_scans[0];
         req_ch.valid   <= 1'b1;
         req_ch.sample0 <= s[0];
         req_ch.sample1 <= s[1];
         req_ch.sample2 <= s[2];
         req_ch.sample3 <= s[3];
         req_ch.sample4 <= s[4];
         req_ch.sample5 <= s[5];
      end else begin
         req_ch.valid <= 1'b0;
      end
   end

   // Result receiver: random stalls, plus the occasional long hold-off.
   always @(negedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Register write; the predictor copy follows only the mapped indexes.
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CFG_BITS-1:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!(csr_ch.valid && csr_ch.ready));
      if (idx == REG_MIN_LEVELS) cal_min = value;
      else if (idx == REG_MAX_LEVELS) cal_max = value;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Wait until every scan is taken and every result is back, then let the
   // divider finish any work that produces no result before touching CSRs.
   task automatic drain();
      while (pending_scans.size() != 0 || req_ch.valid || expected_levels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly uniform bytes, with the rails forced now and then.
   function automatic scan_type random_scan();
      scan_type s;
      int       pick;
      for (int ch = 0; ch < N_CHANNELS; ch++) begin
         pick = $urandom_range(0, 15);
         if (pick == 0) s[ch] = '0;
         else if (pick == 1) s[ch] = '1;
         else s[ch] = SAMPLE_BITS'($urandom_range(0, 255));
      end
      return s;
   endfunction

   // Per channel: mostly a proper min < max window, sometimes an empty or
   // inverted span.
   task automatic random_calibration(output logic [CFG_BITS-1:0] lo_w,
                                     output logic [CFG_BITS-1:0] hi_w);
      int lo;
      int hi;
      for (int ch = 0; ch < N_CHANNELS; ch++) begin
         lo = $urandom_range(0, 220);
         if ($urandom_range(0, 7) == 0) hi = $urandom_range(0, lo);
         else hi = lo + $urandom_range(1, 255 - lo);
         lo_w[ch*SAMPLE_BITS +: SAMPLE_BITS] = SAMPLE_BITS'(lo);
         hi_w[ch*SAMPLE_BITS +: SAMPLE_BITS] = SAMPLE_BITS'(hi);
      end
   endtask

   // Directed scans. Channel 1 and 4 sit at opposite rails so the bias
   // hits +100 with the reset window and -100 with the clamp window.
   function automatic scan_type directed_scan(input int k, input bit clamp_set);
      scan_type s;
      s[0] = (((k & 1) ^ ((k >> 2) & 1)) != 0) ? 8'hFF : 8'h00;
      s[1] = clamp_set ? 8'h00 : 8'hFF;
      s[2] = SAMPLE_BITS'(k * 23);
      s[3] = ~SAMPLE_BITS'(k * 23);
      s[4] = clamp_set ? 8'hFF : 8'h00;
      s[5] = clamp_set ? 8'd130 : (((k & 1) != 0) ? 8'hAA : 8'h55);
      return s;
   endfunction

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   initial begin
      logic [CFG_BITS-1:0] lo_w;
      logic [CFG_BITS-1:0] hi_w;
      int                  count;

      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.sample0 = '0;
      req_ch.sample1 = '0;
      req_ch.sample2 = '0;
      req_ch.sample3 = '0;
      req_ch.sample4 = '0;
      req_ch.sample5 = '0;
      rsp_ch.ready   = 1'b0;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = '0;
      csr_ch.data    = '0;

      cal_min       = '0;
      cal_max       = '1;
      scans_in_mean = 0;
      for (int i = 0; i < 2*N_CHANNELS; i++) triple_hold[i] = '0;
      for (int ch = 0; ch < N_CHANNELS; ch++) median_sum[ch] = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed, reset window (min 0, max 255): rails, medians of extremes.
      send_idle_pct = 14;
      recv_idle_pct = 72;
      for (int k = 0; k < SCANS_PER_MEAN; k++) pending_scans.push_back(directed_scan(k, 1'b0));
      drain();

      // Directed clamp window: below min, empty span, inverted span, above
      // max and a plain mid value. Unmapped indexes must not disturb it.
      write_csr(REG_UNMAPPED_LOW, '1);
      write_csr(REG_MIN_LEVELS, {8'd100, 8'd0, 8'd200, 8'd80, 8'd10, 8'd0});
      write_csr(REG_MAX_LEVELS, {8'd150, 8'd100, 8'd100, 8'd80, 8'd200, 8'd255});
      write_csr(REG_UNMAPPED_TOP, '0);
      for (int k = 0; k < SCANS_PER_MEAN; k++) pending_scans.push_back(directed_scan(k, 1'b1));
      drain();

      // Random phases; partial means deliberately carry across phases.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin lo_w = '0; hi_w = '1; end
            1: begin lo_w = '1; hi_w = '0; end
            2: begin lo_w = '1; hi_w = '1; end
            default: random_calibration(lo_w, hi_w);
         endcase
         write_csr(REG_MIN_LEVELS, lo_w);
         write_csr(REG_MAX_LEVELS, hi_w);
         if (p == 3) write_csr(REG_UNMAPPED_LOW, CFG_BITS'({$urandom, $urandom}));

         if (p < 3) begin
            send_idle_pct = 14;
            recv_idle_pct = 72;
         end else if (p < 6) begin
            send_idle_pct = 72;
            recv_idle_pct = 14;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end

         count = $urandom_range(70, 100);
         for (int i = 0; i < count; i++) pending_scans.push_back(random_scan());

         // Back-pressure: the receiver blocks while the sender keeps going,
         // so an unclaimed result stalls the next twelfth scan.
         if (p == 6) hold_requests++;
         drain();
      end

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(RUN_LIMIT_NS);
      $display("%0t: timeout, %0d results outstanding", $realtime, expected_levels.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

[sim.f]
hdl/mmn_pkg.sv
hdl/mmn_ifs.sv
hdl/mmn_lane.sv
hdl/mmn_merge.sv
hdl/median_mean_normalize_core.sv
bench/tb_top.sv
